>>> rtl/ocia_pkg.sv
// Package for the overflow-checked integer ALU: operand width, saturation
// limits, operation and overflow mode codes, and the item structs of the ports.
// Depends on nothing.
package ocia_pkg;

    // Operand and result width, and the half width used by the multiplier.
    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;

    // Saturation limits in two's complement and unsigned terms.
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] SMIN     = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] SMAX     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] ONE      = {{(DATA_W-1){1'b0}}, 1'b1};

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_CMP = 2'd3
    } op_t;

    // Overflow handling codes.
    typedef enum logic [1:0] {
        MODE_RETURN = 2'd0,
        MODE_TRAP   = 2'd1,
        MODE_WRAP   = 2'd2,
        MODE_SAT    = 2'd3
    } mode_t;

    // One input item.
    typedef struct packed {
        op_t               op;
        logic              is_signed;
        mode_t             overflow_mode;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
    } alu_in_t;

    // One result item.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              overflow_flag;
        logic              trap;
    } alu_out_t;

endpackage

>>> rtl/overflow_checked_integer_alu.sv
// Top level of the overflow-checked integer ALU: a five-stage pipeline with
// add, subtract, compare and a 64x64 multiplier built from 32x32 partial products.
// Depends on ocia_pkg.

// The block accepts one item in every clock cycle; busy is always low. Each
// result appears on result with done high for one cycle, in the order of
// acceptance. The latency is set by the multiplier path: input register,
// operand magnitudes, four registered 32x32 partial products, the partial
// product sum, then the overflow check and mode selection into the result
// register. Add, subtract and compare finish early and travel along with the
// multiplier stages so that every item has the same latency. Results cannot
// be held off, so the receiver must take each one in the cycle that it is
// shown.
module overflow_checked_integer_alu
    import ocia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  alu_in_t  request,
    output logic     done,
    output alu_out_t result
);

    // Per-item control that rides along the pipeline.
    typedef struct packed {
        logic              is_mul;
        logic              sgn;
        mode_t             mode;
        logic              neg;
        logic [DATA_W-1:0] r;
        logic              ovf;
        logic [DATA_W-1:0] sat;
    } ctl_t;

    logic              accept;
    alu_in_t           in_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    ctl_t              c2_reg;
    ctl_t              c3_reg;
    ctl_t              c4_reg;
    ctl_t              c2_next;
    logic [DATA_W-1:0] ma_reg;
    logic [DATA_W-1:0] mb_reg;
    logic [DATA_W-1:0] ma_next;
    logic [DATA_W-1:0] mb_next;
    logic [DATA_W-1:0] p00_reg;
    logic [DATA_W-1:0] p01_reg;
    logic [DATA_W-1:0] p10_reg;
    logic [DATA_W-1:0] p11_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] hi_next;
    logic [DATA_W-1:0] lo_next;
    logic [HALF_W+1:0] mid;
    alu_out_t          result_reg;
    alu_out_t          result_next;
    logic              done_reg;

    logic [DATA_W:0]   sum_ext;
    logic [DATA_W:0]   dif_ext;
    logic [DATA_W-1:0] cmp_x;
    logic [DATA_W-1:0] cmp_y;
    logic [DATA_W-1:0] prod;
    logic              mul_ovf;
    logic [DATA_W-1:0] r_fin;
    logic              ovf_fin;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage two: add, subtract and compare finish here; the multiplier
    // operands are reduced to magnitudes for signed items.
    always_comb
    begin
        sum_ext = {1'b0, in_reg.lhs} + {1'b0, in_reg.rhs};
        dif_ext = {1'b0, in_reg.lhs} - {1'b0, in_reg.rhs};
        cmp_x   = in_reg.is_signed ? (in_reg.lhs ^ SMIN) : in_reg.lhs;
        cmp_y   = in_reg.is_signed ? (in_reg.rhs ^ SMIN) : in_reg.rhs;

        c2_next.is_mul = 1'b0;
        c2_next.sgn    = in_reg.is_signed;
        c2_next.mode   = in_reg.overflow_mode;
        c2_next.neg    = in_reg.is_signed
                         && (in_reg.lhs[DATA_W-1] ^ in_reg.rhs[DATA_W-1]);
        c2_next.r      = '0;
        c2_next.ovf    = 1'b0;
        c2_next.sat    = '0;

        unique case (in_reg.op)
            OP_ADD:
            begin
                c2_next.r = sum_ext[DATA_W-1:0];
                if (in_reg.is_signed)
                begin
                    c2_next.ovf = (in_reg.lhs[DATA_W-1] ^ sum_ext[DATA_W-1])
                                  & (in_reg.rhs[DATA_W-1] ^ sum_ext[DATA_W-1]);
                    c2_next.sat = in_reg.rhs[DATA_W-1] ? SMIN : SMAX;
                end
                else
                begin
                    c2_next.ovf = sum_ext[DATA_W];
                    c2_next.sat = ALL_ONES;
                end
            end
            OP_SUB:
            begin
                c2_next.r = dif_ext[DATA_W-1:0];
                if (in_reg.is_signed)
                begin
                    c2_next.ovf = (in_reg.lhs[DATA_W-1] ^ in_reg.rhs[DATA_W-1])
                                  & (in_reg.lhs[DATA_W-1] ^ dif_ext[DATA_W-1]);
                    c2_next.sat = in_reg.rhs[DATA_W-1] ? SMAX : SMIN;
                end
                else
                begin
                    // A borrow out means rhs was larger than lhs.
                    c2_next.ovf = dif_ext[DATA_W];
                    c2_next.sat = '0;
                end
            end
            OP_MUL:
            begin
                c2_next.is_mul = 1'b1;
                if (in_reg.is_signed)
                begin
                    c2_next.sat = c2_next.neg ? SMIN : SMAX;
                end
                else
                begin
                    c2_next.sat = ALL_ONES;
                end
            end
            OP_CMP:
            begin
                // With no overflow every mode passes the value through.
                if (cmp_x > cmp_y)
                begin
                    c2_next.r = ONE;
                end
                else if (cmp_x < cmp_y)
                begin
                    c2_next.r = ALL_ONES;
                end
                else
                begin
                    c2_next.r = '0;
                end
            end
        endcase

        ma_next = (in_reg.is_signed && in_reg.lhs[DATA_W-1]) ? ((~in_reg.lhs) + ONE)
                                                             : in_reg.lhs;
        mb_next = (in_reg.is_signed && in_reg.rhs[DATA_W-1]) ? ((~in_reg.rhs) + ONE)
                                                             : in_reg.rhs;
    end

    // Stage four: sum the partial products into the full unsigned product.
    always_comb
    begin
        mid = {2'b00, p00_reg[DATA_W-1:HALF_W]}
              + {2'b00, p01_reg[HALF_W-1:0]}
              + {2'b00, p10_reg[HALF_W-1:0]};
        lo_next = {mid[HALF_W-1:0], p00_reg[HALF_W-1:0]};
        hi_next = p11_reg
                  + {{HALF_W{1'b0}}, p01_reg[DATA_W-1:HALF_W]}
                  + {{HALF_W{1'b0}}, p10_reg[DATA_W-1:HALF_W]}
                  + {{(DATA_W-2){1'b0}}, mid[HALF_W+1:HALF_W]};
    end

    // Stage five: restore the product sign, check the product range and
    // apply the overflow mode.
    always_comb
    begin
        prod    = c4_reg.neg ? ((~lo_reg) + ONE) : lo_reg;
        mul_ovf = (hi_reg != '0)
                  || (c4_reg.sgn && (lo_reg > (c4_reg.neg ? SMIN : SMAX)));
        r_fin   = c4_reg.is_mul ? prod : c4_reg.r;
        ovf_fin = c4_reg.is_mul ? mul_ovf : c4_reg.ovf;

        result_next.value         = r_fin;
        result_next.overflow_flag = 1'b0;
        result_next.trap          = 1'b0;

        unique case (c4_reg.mode)
            MODE_RETURN:
            begin
                result_next.overflow_flag = ovf_fin;
            end
            MODE_TRAP:
            begin
                result_next.trap  = ovf_fin;
                result_next.value = ovf_fin ? '0 : r_fin;
            end
            MODE_WRAP:
            begin
                result_next.value = r_fin;
            end
            MODE_SAT:
            begin
                result_next.value = ovf_fin ? c4_reg.sat : r_fin;
            end
        endcase
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Payload registers of the pipeline stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= request;
        end
        c2_reg     <= c2_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        c3_reg     <= c2_reg;
        p00_reg    <= {{HALF_W{1'b0}}, ma_reg[HALF_W-1:0]}
                      * {{HALF_W{1'b0}}, mb_reg[HALF_W-1:0]};
        p01_reg    <= {{HALF_W{1'b0}}, ma_reg[HALF_W-1:0]}
                      * {{HALF_W{1'b0}}, mb_reg[DATA_W-1:HALF_W]};
        p10_reg    <= {{HALF_W{1'b0}}, ma_reg[DATA_W-1:HALF_W]}
                      * {{HALF_W{1'b0}}, mb_reg[HALF_W-1:0]};
        p11_reg    <= {{HALF_W{1'b0}}, ma_reg[DATA_W-1:HALF_W]}
                      * {{HALF_W{1'b0}}, mb_reg[DATA_W-1:HALF_W]};
        c4_reg     <= c3_reg;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Every accepted item yields exactly one result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted item produced no result after five cycles");

    // A compare never flags and yields only -1, 0 or 1.
    a_cmp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.op == OP_CMP) |-> ##5
            (!result.overflow_flag && !result.trap
             && (result.value == '0 || result.value == ONE
                 || result.value == ALL_ONES)))
        else $error("compare result out of range or flagged");

    // Wrap and saturate modes never raise a flag or a trap.
    a_quiet_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.overflow_mode == MODE_WRAP
                    || request.overflow_mode == MODE_SAT)) |-> ##5
            (!result.overflow_flag && !result.trap))
        else $error("flag or trap raised outside return and trap modes");

    // A trap always comes with a zero value.
    a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && c4_reg.mode == MODE_TRAP && ovf_fin) |=>
            (done && result.trap && result.value == '0))
        else $error("trap result not signaled with zero value");
`endif

endmodule
